// ===== rtl/core/rplr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rplr_pkg
// Shared widths, constants, types and the arctangent table for the linear
// phase ramp rotator.
// ----------------------------------------------------------------------------
package rplr_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int LINE_IDX_W     = 10;
    localparam int LINE_CNT_W     = 11;
    localparam int PHASE_W        = 32;
    localparam int POS_W          = LINE_CNT_W + 1;
    localparam int GUARD_BITS     = 14;
    localparam int XY_W           = SAMPLE_BITS + GUARD_BITS + 2;
    localparam int Z_W            = PHASE_W;
    localparam int CORDIC_STEPS   = 28;
    localparam int STEP_W         = 5;
    localparam int INV_GAIN_W     = 31;
    localparam int PRESCALE_SHIFT = 30 - GUARD_BITS;
    localparam int PROD_W         = SAMPLE_BITS + INV_GAIN_W;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 32;

    localparam logic [INV_GAIN_W-1:0] INV_GAIN_Q30   = INV_GAIN_W'(652032875);
    localparam logic [LINE_CNT_W-1:0] LINE_COUNT_RST = LINE_CNT_W'(1024);
    localparam logic [PHASE_W-1:0]    EIGHTH_TURN    = PHASE_W'(1) << (PHASE_W - 3);
    localparam logic signed [XY_W-1:0] ROUND_HALF    = XY_W'(1) << (GUARD_BITS - 1);
    localparam logic signed [XY_W-1:0] SAT_HI        = XY_W'(2**(SAMPLE_BITS-1) - 1);
    localparam logic signed [XY_W-1:0] SAT_LO        = ~SAT_HI;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP = 1'b0,
        CFG_LINE_COUNT = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quadrant;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_rot_word;

    // atan(2^-i) in 2^-32 turn units
    function automatic logic [Z_W-1:0] turn_atan(input logic [STEP_W-1:0] step);
        logic [Z_W-1:0] v;
        case (step)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rplr_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rplr_in_if
// Sample channel: complex sample and its line index, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rplr_in_if;
    logic                                         valid;
    logic                                         ready;
    logic signed [rplr_pkg::SAMPLE_BITS-1:0]      sample_re;
    logic signed [rplr_pkg::SAMPLE_BITS-1:0]      sample_im;
    logic        [rplr_pkg::LINE_IDX_W-1:0]       line_index;

    modport source (output valid, output sample_re, output sample_im,
                    output line_index, input ready);
    modport sink   (input valid, input sample_re, input sample_im,
                    input line_index, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rplr_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rplr_out_if
// Result channel: rotated complex sample, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rplr_out_if;
    logic                                         valid;
    logic                                         ready;
    logic signed [rplr_pkg::SAMPLE_BITS-1:0]      rotated_re;
    logic signed [rplr_pkg::SAMPLE_BITS-1:0]      rotated_im;

    modport source (output valid, output rotated_re, output rotated_im, input ready);
    modport sink   (input valid, input rotated_re, input rotated_im, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/linear_phase_ramp_rotator_unit.sv =====
// Pipeline: 3 front stages, 28 CORDIC stages and 1 round/saturate output
// register between an accepted sample word and its result word.
// Throughput: one word per cycle while the output is ready; each stage holds
// on its own when the next one is full, so gaps in the pipeline close up under back-pressure.
// Reset: all stage valid bits clear, phase_step reads 0, line_count 1024.
`default_nettype none
// ----------------------------------------------------------------------------
// linear_phase_ramp_rotator_unit
// Rotates each complex sample by phase_step times its signed line position,
// using a fully pipelined fixed-point CORDIC.
// ----------------------------------------------------------------------------
module linear_phase_ramp_rotator_unit (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [rplr_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [rplr_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    rplr_in_if.sink                                    i_in,
    rplr_out_if.source                                 o_out
);

    logic [rplr_pkg::PHASE_W-1:0]      r_phase_step;
    logic [rplr_pkg::LINE_CNT_W-1:0]   r_line_count;

    rplr_pkg::t_rot_word               w_word  [rplr_pkg::CORDIC_STEPS+1];
    logic                              w_valid [rplr_pkg::CORDIC_STEPS+1];
    logic                              w_ready [rplr_pkg::CORDIC_STEPS+1];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0;
            r_line_count <= rplr_pkg::LINE_COUNT_RST;
        end else if (i_cfg_we) begin
            case (rplr_pkg::t_cfg_idx'(i_cfg_idx))
                rplr_pkg::CFG_PHASE_STEP: begin
                    r_phase_step <= i_cfg_data[rplr_pkg::PHASE_W-1:0];
                end
                rplr_pkg::CFG_LINE_COUNT: begin
                    r_line_count <= i_cfg_data[rplr_pkg::LINE_CNT_W-1:0];
                end
                default: begin
                    r_line_count <= r_line_count;
                end
            endcase
        end
    end

    rplr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_phase_step (r_phase_step),
        .i_line_count (r_line_count),
        .i_valid      (i_in.valid),
        .o_ready      (i_in.ready),
        .i_re         (i_in.sample_re),
        .i_im         (i_in.sample_im),
        .i_idx        (i_in.line_index),
        .o_valid      (w_valid[0]),
        .i_ready      (w_ready[0]),
        .o_word       (w_word[0])
    );

    for (genvar k = 0; k < rplr_pkg::CORDIC_STEPS; k++) begin : g_cordic
        rplr_cordic_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (rplr_pkg::STEP_W'(k)),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_word  (w_word[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_word  (w_word[k+1])
        );
    end

    rplr_round_sat u_round_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[rplr_pkg::CORDIC_STEPS]),
        .o_ready (w_ready[rplr_pkg::CORDIC_STEPS]),
        .i_word  (w_word[rplr_pkg::CORDIC_STEPS]),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_re    (o_out.rotated_re),
        .o_im    (o_out.rotated_im)
    );

endmodule
`default_nettype wire

// ===== rtl/core/rplr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rplr_front
// Three stages: signed line position, phase multiply and gain prescale,
// quadrant fold with quarter-turn prerotation.
// ----------------------------------------------------------------------------
module rplr_front (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic        [rplr_pkg::PHASE_W-1:0]       i_phase_step,
    input  wire logic        [rplr_pkg::LINE_CNT_W-1:0]    i_line_count,
    input  wire logic                                      i_valid,
    output      logic                                      o_ready,
    input  wire logic signed [rplr_pkg::SAMPLE_BITS-1:0]   i_re,
    input  wire logic signed [rplr_pkg::SAMPLE_BITS-1:0]   i_im,
    input  wire logic        [rplr_pkg::LINE_IDX_W-1:0]    i_idx,
    output      logic                                      o_valid,
    input  wire logic                                      i_ready,
    output      rplr_pkg::t_rot_word                       o_word
);

    logic en_a, en_b, en_c;

    logic                                       r_va, r_vb, r_vc;
    logic signed [rplr_pkg::SAMPLE_BITS-1:0]    r_a_re, r_a_im;
    logic signed [rplr_pkg::POS_W-1:0]          r_a_pos;
    logic        [rplr_pkg::PHASE_W-1:0]        r_b_ang;
    logic signed [rplr_pkg::XY_W-1:0]           r_b_x, r_b_y;
    rplr_pkg::t_rot_word                        r_c_word;

    logic        [rplr_pkg::LINE_CNT_W-1:0]     idx_ext;
    logic        [rplr_pkg::LINE_CNT_W-1:0]     half;
    logic        [rplr_pkg::POS_W-1:0]          n_pos;

    logic signed [rplr_pkg::PHASE_W+rplr_pkg::POS_W-1:0] prod_ang;
    logic signed [rplr_pkg::PROD_W-1:0]         prod_re, prod_im, sh_re, sh_im;

    logic        [rplr_pkg::PHASE_W-1:0]        ang_rnd, resid;
    rplr_pkg::t_quadrant                        quad;
    rplr_pkg::t_rot_word                        n_word;

    assign en_c    = !r_vc || i_ready;
    assign en_b    = !r_vb || en_c;
    assign en_a    = !r_va || en_b;
    assign o_ready = en_a;
    assign o_valid = r_vc;
    assign o_word  = r_c_word;

    // signed line position
    always_comb begin
        idx_ext = {1'b0, i_idx};
        half    = {1'b0, i_line_count[rplr_pkg::LINE_CNT_W-1:1]};
        if (idx_ext < half) begin
            n_pos = {1'b0, idx_ext};
        end else begin
            n_pos = {1'b0, idx_ext} - {1'b0, i_line_count};
        end
    end

    // phase angle and prescale by inverse gain
    always_comb begin
        prod_ang = $signed(i_phase_step) * r_a_pos;
        prod_re  = r_a_re * $signed(rplr_pkg::INV_GAIN_Q30);
        prod_im  = r_a_im * $signed(rplr_pkg::INV_GAIN_Q30);
        sh_re    = prod_re >>> rplr_pkg::PRESCALE_SHIFT;
        sh_im    = prod_im >>> rplr_pkg::PRESCALE_SHIFT;
    end

    // quadrant fold and prerotation
    always_comb begin
        ang_rnd  = r_b_ang + rplr_pkg::EIGHTH_TURN;
        quad     = rplr_pkg::t_quadrant'(ang_rnd[rplr_pkg::PHASE_W-1 -: 2]);
        resid    = r_b_ang - {ang_rnd[rplr_pkg::PHASE_W-1 -: 2],
                              {(rplr_pkg::PHASE_W-2){1'b0}}};
        n_word.z = $signed(resid);
        case (quad)
            rplr_pkg::QUAD_1: begin
                n_word.x = -r_b_y;
                n_word.y = r_b_x;
            end
            rplr_pkg::QUAD_2: begin
                n_word.x = -r_b_x;
                n_word.y = -r_b_y;
            end
            rplr_pkg::QUAD_3: begin
                n_word.x = r_b_y;
                n_word.y = -r_b_x;
            end
            default: begin
                n_word.x = r_b_x;
                n_word.y = r_b_y;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= i_valid;
            end
            if (en_b) begin
                r_vb <= r_va;
            end
            if (en_c) begin
                r_vc <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_re  <= i_re;
            r_a_im  <= i_im;
            r_a_pos <= $signed(n_pos);
        end
        if (en_b) begin
            r_b_ang <= prod_ang[rplr_pkg::PHASE_W-1:0];
            r_b_x   <= sh_re[rplr_pkg::XY_W-1:0];
            r_b_y   <= sh_im[rplr_pkg::XY_W-1:0];
        end
        if (en_c) begin
            r_c_word <= n_word;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/rplr_cordic_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rplr_cordic_stage
// One registered CORDIC micro-rotation; the step number selects shift and
// arctangent.
// ----------------------------------------------------------------------------
module rplr_cordic_stage (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [rplr_pkg::STEP_W-1:0]       i_step,
    input  wire logic                              i_valid,
    output      logic                              o_ready,
    input  wire rplr_pkg::t_rot_word               i_word,
    output      logic                              o_valid,
    input  wire logic                              i_ready,
    output      rplr_pkg::t_rot_word               o_word
);

    logic                               en;
    logic                               r_v;
    rplr_pkg::t_rot_word                r_word;
    rplr_pkg::t_rot_word                n_word;
    logic signed [rplr_pkg::XY_W-1:0]   dx, dy;
    logic signed [rplr_pkg::Z_W-1:0]    dz;

    assign en      = !r_v || i_ready;
    assign o_ready = en;
    assign o_valid = r_v;
    assign o_word  = r_word;

    always_comb begin
        dx = i_word.y >>> i_step;
        dy = i_word.x >>> i_step;
        dz = $signed(rplr_pkg::turn_atan(i_step));
        if (!i_word.z[rplr_pkg::Z_W-1]) begin
            n_word.x = i_word.x - dx;
            n_word.y = i_word.y + dy;
            n_word.z = i_word.z - dz;
        end else begin
            n_word.x = i_word.x + dx;
            n_word.y = i_word.y - dy;
            n_word.z = i_word.z + dz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_word <= n_word;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/rplr_round_sat.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rplr_round_sat
// Drops the guard bits with round-half-up, saturates to the sample range
// and holds the result word in the output register.
// ----------------------------------------------------------------------------
module rplr_round_sat (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_valid,
    output      logic                                      o_ready,
    input  wire rplr_pkg::t_rot_word                       i_word,
    output      logic                                      o_valid,
    input  wire logic                                      i_ready,
    output      logic signed [rplr_pkg::SAMPLE_BITS-1:0]   o_re,
    output      logic signed [rplr_pkg::SAMPLE_BITS-1:0]   o_im
);

    logic                                       en;
    logic                                       r_v;
    logic signed [rplr_pkg::SAMPLE_BITS-1:0]    r_re, r_im;
    logic signed [rplr_pkg::XY_W-1:0]           rnd_re, rnd_im;
    logic signed [rplr_pkg::SAMPLE_BITS-1:0]    n_re, n_im;

    assign en      = !r_v || i_ready;
    assign o_ready = en;
    assign o_valid = r_v;
    assign o_re    = r_re;
    assign o_im    = r_im;

    always_comb begin
        rnd_re = (i_word.x + rplr_pkg::ROUND_HALF) >>> rplr_pkg::GUARD_BITS;
        rnd_im = (i_word.y + rplr_pkg::ROUND_HALF) >>> rplr_pkg::GUARD_BITS;
        if (rnd_re > rplr_pkg::SAT_HI) begin
            n_re = rplr_pkg::SAT_HI[rplr_pkg::SAMPLE_BITS-1:0];
        end else if (rnd_re < rplr_pkg::SAT_LO) begin
            n_re = rplr_pkg::SAT_LO[rplr_pkg::SAMPLE_BITS-1:0];
        end else begin
            n_re = rnd_re[rplr_pkg::SAMPLE_BITS-1:0];
        end
        if (rnd_im > rplr_pkg::SAT_HI) begin
            n_im = rplr_pkg::SAT_HI[rplr_pkg::SAMPLE_BITS-1:0];
        end else if (rnd_im < rplr_pkg::SAT_LO) begin
            n_im = rplr_pkg::SAT_LO[rplr_pkg::SAMPLE_BITS-1:0];
        end else begin
            n_im = rnd_im[rplr_pkg::SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_re <= n_re;
            r_im <= n_im;
        end
    end

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Streams complex samples with line indexes into the ramp rotator under several
// phase step and line count settings. Each accepted word is rotated by a bit-true
// fixed-point predictor or taken from a typed table row, then compared with the output.
// ----------------------------------------------------------------------------
module testbench;

    localparam longint GAIN_COMP_Q30 = 652032875;
    localparam int     PRESCALE_BITS = 16;
    localparam int     FRAC_BITS     = 14;
    localparam longint HALF_LSB      = 64'sd8192;
    localparam longint SAMPLE_MAX    = 64'sd32767;
    localparam longint SAMPLE_MIN    = -64'sd32768;
    localparam logic [rplr_pkg::PHASE_W-1:0] ANGLE_BIAS = 32'h2000_0000;
    localparam int     ROTATION_STEPS = 28;
    localparam int     PROBE_ROWS     = 22;
    localparam int     RANDOM_PHASES  = 8;
    localparam int     WORDS_PER_PHASE = 70;

    typedef struct packed {
        logic signed [rplr_pkg::SAMPLE_BITS-1:0] re;
        logic signed [rplr_pkg::SAMPLE_BITS-1:0] im;
    } rotated_word_t;

    typedef struct packed {
        logic [rplr_pkg::PHASE_W-1:0]            step;
        logic [rplr_pkg::LINE_CNT_W-1:0]         count;
        logic signed [rplr_pkg::SAMPLE_BITS-1:0] re;
        logic signed [rplr_pkg::SAMPLE_BITS-1:0] im;
        logic [rplr_pkg::LINE_IDX_W-1:0]         line;
        logic                                    typed;
        rotated_word_t                           want;
    } probe_row_t;

    // atan(2^-i) in 2^-32 turn units
    longint arctan_turn [0:ROTATION_STEPS-1] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005
    };

    // step, count, re, im, line, typed, expected word
    probe_row_t probe_rows [0:PROBE_ROWS-1] = '{
        '{32'h0000_0000, 11'd1024, 0, 0, 10'd0, 1'b1, '{0, 0}},
        '{32'h0000_0000, 11'd1024, 32767, -32768, 10'd1023, 1'b1, '{32767, -32768}},
        '{32'h0000_0000, 11'd1024, 12345, -23456, 10'd511, 1'b0, '{0, 0}},
        '{32'h8000_0000, 11'd1024, -32768, -32768, 10'd1, 1'b1, '{32767, 32767}},
        '{32'h8000_0000, 11'd1024, 20000, -7000, 10'd2, 1'b0, '{0, 0}},
        '{32'h8000_0000, 11'd1024, 32767, 32767, 10'd1023, 1'b0, '{0, 0}},
        '{32'h4000_0000, 11'd1024, -32768, 0, 10'd1, 1'b1, '{0, -32768}},
        '{32'h4000_0000, 11'd1024, 1000, -2000, 10'd1023, 1'b0, '{0, 0}},
        '{32'h4000_0000, 11'd1024, 30000, 20000, 10'd512, 1'b0, '{0, 0}},
        '{32'h4000_0000, 11'd1024, 30000, 20000, 10'd511, 1'b0, '{0, 0}},
        '{32'h7FFF_FFFF, 11'd2, 32767, 32767, 10'd0, 1'b0, '{0, 0}},
        '{32'h7FFF_FFFF, 11'd2, -32768, 32767, 10'd1, 1'b0, '{0, 0}},
        '{32'h7FFF_FFFF, 11'd2, 4096, -4096, 10'd1023, 1'b0, '{0, 0}},
        '{32'h2000_0000, 11'd0, 32767, 32767, 10'd1, 1'b0, '{0, 0}},
        '{32'h2000_0000, 11'd0, -32768, -32768, 10'd1023, 1'b0, '{0, 0}},
        '{32'h1FFF_FFFF, 11'd1, 25000, -25000, 10'd0, 1'b0, '{0, 0}},
        '{32'h6000_0000, 11'd2047, 32767, 0, 10'd1022, 1'b0, '{0, 0}},
        '{32'h6000_0000, 11'd2047, 0, 32767, 10'd1023, 1'b0, '{0, 0}},
        '{32'hDFFF_FFFF, 11'd5, -12000, 31000, 10'd700, 1'b0, '{0, 0}},
        '{32'hFFFF_FFFF, 11'd5, 32767, -1, 10'd2, 1'b0, '{0, 0}},
        '{32'hFFFF_FFFF, 11'd5, -1, 32767, 10'd3, 1'b0, '{0, 0}},
        '{32'hE000_0000, 11'd1024, -32768, 32767, 10'd1, 1'b0, '{0, 0}}
    };

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [rplr_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [rplr_pkg::CFG_DATA_W-1:0] i_cfg_data;

    rplr_in_if  sample_ch ();
    rplr_out_if rotated_ch ();

    linear_phase_ramp_rotator_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (sample_ch),
        .o_out      (rotated_ch)
    );

    logic [rplr_pkg::PHASE_W-1:0]    ramp_step  = '0;
    logic [rplr_pkg::LINE_CNT_W-1:0] ramp_lines = rplr_pkg::LINE_CNT_W'(1024);
    rotated_word_t         pending_rotations [$];
    int                    send_gap_pct   = 0;
    int                    recv_stall_pct = 0;
    int                    fail_count     = 0;
    int                    words_sent     = 0;
    int                    words_checked  = 0;
    int                    settings_used  = 1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d rotated words outstanding", pending_rotations.size());
        $display("tb: failure");
        $finish;
    end

    function automatic logic signed [rplr_pkg::SAMPLE_BITS-1:0] round_to_sample(
        input longint v
    );
        longint r;
        r = (v + HALF_LSB) >>> FRAC_BITS;
        if (r > SAMPLE_MAX)
            r = SAMPLE_MAX;
        if (r < SAMPLE_MIN)
            r = SAMPLE_MIN;
        return r[rplr_pkg::SAMPLE_BITS-1:0];
    endfunction

    function automatic rotated_word_t rotate_by_ramp(
        input logic signed [rplr_pkg::SAMPLE_BITS-1:0] re,
        input logic signed [rplr_pkg::SAMPLE_BITS-1:0] im,
        input logic [rplr_pkg::LINE_IDX_W-1:0]         line,
        input logic [rplr_pkg::PHASE_W-1:0]            step,
        input logic [rplr_pkg::LINE_CNT_W-1:0]         count
    );
        longint                       pos, x0, y0, x, y, z, dx, dy;
        logic [rplr_pkg::PHASE_W-1:0] angle, lifted, resid;
        rplr_pkg::t_quadrant          quad;
        rotated_word_t                res;
        // signed line position, wraps at half the line count
        if (longint'(line) < longint'(count / 2))
            pos = longint'(line);
        else
            pos = longint'(line) - longint'(count);
        angle  = rplr_pkg::PHASE_W'(longint'($signed(step)) * pos);
        lifted = angle + ANGLE_BIAS;
        quad   = rplr_pkg::t_quadrant'(lifted[rplr_pkg::PHASE_W-1:rplr_pkg::PHASE_W-2]);
        resid  = angle - {lifted[rplr_pkg::PHASE_W-1:rplr_pkg::PHASE_W-2], 30'd0};
        z      = longint'($signed(resid));
        x0     = (longint'(re) * GAIN_COMP_Q30) >>> PRESCALE_BITS;
        y0     = (longint'(im) * GAIN_COMP_Q30) >>> PRESCALE_BITS;
        case (quad)
            rplr_pkg::QUAD_1: begin
                x = -y0;
                y = x0;
            end
            rplr_pkg::QUAD_2: begin
                x = -x0;
                y = -y0;
            end
            rplr_pkg::QUAD_3: begin
                x = y0;
                y = -x0;
            end
            default: begin
                x = x0;
                y = y0;
            end
        endcase
        for (int i = 0; i < ROTATION_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_turn[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_turn[i];
            end
        end
        res.re = round_to_sample(x);
        res.im = round_to_sample(y);
        return res;
    endfunction

    function automatic logic signed [rplr_pkg::SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            default: return rplr_pkg::SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [rplr_pkg::LINE_IDX_W-1:0] pick_line();
        logic [rplr_pkg::LINE_IDX_W-1:0] half;
        half = rplr_pkg::LINE_IDX_W'(ramp_lines / 2);
        case ($urandom_range(3))
            0:       return half;
            1:       return half - 1'b1;
            default: return rplr_pkg::LINE_IDX_W'($urandom_range(1023));
        endcase
    endfunction

    function automatic logic [rplr_pkg::PHASE_W-1:0] pick_step();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(2000000) - 1000000;
            2:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return ($urandom_range(7) << 29) + $urandom_range(8) - 4;
        endcase
    endfunction

    function automatic logic [rplr_pkg::LINE_CNT_W-1:0] pick_count();
        case ($urandom_range(4))
            0:       return rplr_pkg::LINE_CNT_W'(2);
            1:       return rplr_pkg::LINE_CNT_W'(1024);
            2:       return rplr_pkg::LINE_CNT_W'($urandom_range(1024, 2));
            default: return rplr_pkg::LINE_CNT_W'($urandom_range(2047));
        endcase
    endfunction

    // called on a falling edge, returns on a falling edge
    task automatic program_regs(input logic [rplr_pkg::PHASE_W-1:0] step,
                                input logic [rplr_pkg::CFG_DATA_W-1:0] count_word);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= rplr_pkg::CFG_PHASE_STEP;
        i_cfg_data <= step;
        @(negedge i_clk);
        i_cfg_idx  <= rplr_pkg::CFG_LINE_COUNT;
        i_cfg_data <= count_word;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        ramp_step  = step;
        ramp_lines = count_word[rplr_pkg::LINE_CNT_W-1:0];
        settings_used++;
    endtask

    task automatic send_word(input logic signed [rplr_pkg::SAMPLE_BITS-1:0] re,
                             input logic signed [rplr_pkg::SAMPLE_BITS-1:0] im,
                             input logic [rplr_pkg::LINE_IDX_W-1:0]         line,
                             input logic                                    typed,
                             input rotated_word_t                           want);
        while ($urandom_range(99) < send_gap_pct) begin
            sample_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.sample_re  <= re;
        sample_ch.sample_im  <= im;
        sample_ch.line_index <= line;
        do @(posedge i_clk); while (!sample_ch.ready);
        pending_rotations.push_back(typed ? want
                                          : rotate_by_ramp(re, im, line, ramp_step, ramp_lines));
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        sample_ch.valid <= 1'b0;
        while (pending_rotations.size() != 0)
            @(negedge i_clk);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        rotated_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : check_rotated
        rotated_word_t want;
        if (i_rst_n && rotated_ch.valid && rotated_ch.ready) begin
            if (pending_rotations.size() == 0) begin
                $error("rotated word (%0d, %0d) with none outstanding",
                       rotated_ch.rotated_re, rotated_ch.rotated_im);
                fail_count++;
            end else begin
                want = pending_rotations.pop_front();
                if (rotated_ch.rotated_re !== want.re) begin
                    $error("rotated_re: expected %0d, actual %0d", want.re,
                           rotated_ch.rotated_re);
                    fail_count++;
                end
                if (rotated_ch.rotated_im !== want.im) begin
                    $error("rotated_im: expected %0d, actual %0d", want.im,
                           rotated_ch.rotated_im);
                    fail_count++;
                end
                words_checked++;
            end
        end
    end

    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = rplr_pkg::CFG_PHASE_STEP;
        i_cfg_data           = '0;
        sample_ch.valid      = 1'b0;
        sample_ch.sample_re  = '0;
        sample_ch.sample_im  = '0;
        sample_ch.line_index = '0;
        rotated_ch.ready     = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, first rows run on the reset settings
        for (int n = 0; n < PROBE_ROWS; n++) begin
            if (probe_rows[n].step != ramp_step || probe_rows[n].count != ramp_lines) begin
                wait_for_results();
                program_regs(probe_rows[n].step,
                             rplr_pkg::CFG_DATA_W'(probe_rows[n].count));
            end
            send_word(probe_rows[n].re, probe_rows[n].im, probe_rows[n].line,
                      probe_rows[n].typed, probe_rows[n].want);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_for_results();
            // upper data bits are junk for the line count write
            program_regs(pick_step(), {21'($urandom), pick_count()});
            case (p % 4)
                0: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_gap_pct   = 63;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 63;
                end
                default: begin
                    send_gap_pct   = 24;
                    recv_stall_pct = 24;
                end
            endcase
            repeat (WORDS_PER_PHASE)
                send_word(pick_sample(), pick_sample(), pick_line(), 1'b0, '0);
        end

        wait_for_results();
        repeat (40) @(negedge i_clk);
        $display("summary: %0d sample words sent, %0d rotated words checked",
                 words_sent, words_checked);
        $display("summary: %0d register settings, sender and receiver idling up to 63%%",
                 settings_used);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/rplr_pkg.sv
rtl/core/rplr_in_if.sv
rtl/core/rplr_out_if.sv
rtl/core/rplr_front.sv
rtl/core/rplr_cordic_stage.sv
rtl/core/rplr_round_sat.sv
rtl/core/linear_phase_ramp_rotator_unit.sv
verif/testbench.sv
